@@ src/ilist_pkg.sv @@
`default_nettype none

package ilist_pkg;

  localparam int MODE_W = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 9;
  localparam int STS_W  = 3;
  localparam int LEN_W  = 9;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MAX    = 3'd5;

  localparam logic [STS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STS_W-1:0] STS_FULL     = 3'd1;
  localparam logic [STS_W-1:0] STS_RANGE    = 3'd2;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

@@ src/ilist_if.sv @@
`default_nettype none

interface ilist_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ilist_pkg::MODE_W-1:0]  mode;
  logic signed [ilist_pkg::VAL_W-1:0]   value;
  logic        [ilist_pkg::POS_W-1:0]   position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface ilist_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ilist_pkg::STS_W-1:0]   status;
  logic signed [ilist_pkg::VAL_W-1:0]   answer;
  logic        [ilist_pkg::LEN_W-1:0]   length;

  modport source (output valid, output status, output answer, output length, input ready);
  modport sink   (input valid, input status, input answer, input length, output ready);
endinterface

`default_nettype wire

@@ src/indexed_integer_list_engine_unit.sv @@
// Channel  Dir  Beat fields                    Handshake
// in_ch    in   mode[2:0] value[31:0] pos[8:0] valid/ready
// out_ch   out  status[2:0] answer[31:0] len   valid/ready
//
// Requests that move or read no entry (append, errors, empty list) skip the walk state.
// Count, find and maximum on a non-empty list walk every entry; when entries move, insert
// walks from the last entry down to position and remove from position + 1 up. The single read
// port of the entry memory sets this: one entry is read, compared or moved per cycle.
// Reset (rst_n low, synchronous) empties the list and drops any waiting result.
// A result beat held by out_ch.ready stalls only the finish of the next request.
`default_nettype none

module indexed_integer_list_engine_unit #(
  parameter int DEPTH = 256
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ilist_in_if.sink  in_ch,
  ilist_out_if.source out_ch
);

  ilist_pkg::cmd_t cmd;
  ilist_pkg::sts_t sts;

  ilist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ilist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_ch.mode),
    .in_value    (in_ch.value),
    .in_position (in_ch.position),
    .out_status  (out_ch.status),
    .out_answer  (out_ch.answer),
    .out_length  (out_ch.length)
  );

endmodule

`default_nettype wire

@@ src/ilist_dp.sv @@
`default_nettype none

module ilist_dp #(
  parameter int DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ilist_pkg::cmd_t                     cmd,
  output      ilist_pkg::sts_t                     sts,
  input  wire logic        [ilist_pkg::MODE_W-1:0] in_mode,
  input  wire logic signed [ilist_pkg::VAL_W-1:0]  in_value,
  input  wire logic        [ilist_pkg::POS_W-1:0]  in_position,
  output      logic        [ilist_pkg::STS_W-1:0]  out_status,
  output      logic signed [ilist_pkg::VAL_W-1:0]  out_answer,
  output      logic        [ilist_pkg::LEN_W-1:0]  out_length
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > ilist_pkg::POS_W) ? CW : ilist_pkg::POS_W) + 1;

  logic [ilist_pkg::VAL_W-1:0] mem [DEPTH];

  logic        [ilist_pkg::MODE_W-1:0] mode_r;
  logic        [ilist_pkg::VAL_W-1:0]  value_r;
  logic        [ilist_pkg::POS_W-1:0]  pos_r;
  logic        [CW-1:0]                cnt_r;
  logic        [AW-1:0]                rd_idx_r;
  logic        [AW-1:0]                proc_idx_r;
  logic                                rd_vld_r;
  logic        [ilist_pkg::VAL_W-1:0]  rd_data_r;
  logic        [CW-1:0]                acc_r;
  logic                                hit_r;
  logic        [AW-1:0]                hit_idx_r;
  logic signed [ilist_pkg::VAL_W-1:0]  best_r;
  logic        [ilist_pkg::STS_W-1:0]  status_r;
  logic signed [ilist_pkg::VAL_W-1:0]  answer_r;
  logic        [ilist_pkg::LEN_W-1:0]  length_r;

  logic [XW-1:0]                pos_x;
  logic [XW-1:0]                n_x;
  logic                         full;
  logic [ilist_pkg::STS_W-1:0]  err;
  logic                         walk;
  logic                         down;
  logic [XW-1:0]                start_x;
  logic [XW-1:0]                end_x;
  logic [CW-1:0]                len_nxt;
  logic [ilist_pkg::STS_W-1:0]  status_nxt;
  logic signed [ilist_pkg::VAL_W-1:0] answer_nxt;
  logic                         pmatch;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [ilist_pkg::VAL_W-1:0]  wr_data;

  assign pos_x  = XW'(pos_r);
  assign n_x    = XW'(cnt_r);
  assign full   = (n_x == XW'(DEPTH));
  assign pmatch = (rd_data_r == value_r);

  always_comb begin
    err     = ilist_pkg::STS_OK;
    walk    = 1'b0;
    down    = 1'b0;
    start_x = '0;
    end_x   = '0;
    len_nxt = cnt_r;
    case (mode_r)
      ilist_pkg::MODE_APPEND: begin
        if (full) begin
          err = ilist_pkg::STS_FULL;
        end else begin
          len_nxt = cnt_r + CW'(1);
        end
      end
      ilist_pkg::MODE_INSERT: begin
        if (pos_x > n_x) begin
          err = ilist_pkg::STS_RANGE;
        end else if (full) begin
          err = ilist_pkg::STS_FULL;
        end else begin
          len_nxt = cnt_r + CW'(1);
          walk    = (pos_x < n_x);
          down    = 1'b1;
          start_x = n_x - XW'(1);
          end_x   = pos_x;
        end
      end
      ilist_pkg::MODE_REMOVE: begin
        if (pos_x >= n_x) begin
          err = ilist_pkg::STS_RANGE;
        end else begin
          len_nxt = cnt_r - CW'(1);
          walk    = ((pos_x + XW'(1)) < n_x);
          start_x = pos_x + XW'(1);
          end_x   = n_x - XW'(1);
        end
      end
      ilist_pkg::MODE_COUNT, ilist_pkg::MODE_FIND: begin
        walk  = (n_x != '0);
        end_x = n_x - XW'(1);
      end
      ilist_pkg::MODE_MAX: begin
        if (n_x == '0) begin
          err = ilist_pkg::STS_EMPTY;
        end else begin
          walk  = 1'b1;
          end_x = n_x - XW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.walk = walk;
  assign sts.last = (rd_idx_r == end_x[AW-1:0]);

  always_comb begin
    status_nxt = err;
    answer_nxt = '0;
    case (mode_r)
      ilist_pkg::MODE_COUNT: answer_nxt = ilist_pkg::VAL_W'(acc_r);
      ilist_pkg::MODE_FIND: begin
        if (hit_r) begin
          answer_nxt = ilist_pkg::VAL_W'(hit_idx_r);
        end else begin
          status_nxt = ilist_pkg::STS_NOTFOUND;
        end
      end
      ilist_pkg::MODE_MAX: begin
        if (err == ilist_pkg::STS_OK) begin
          answer_nxt = best_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_r;
    wr_data = rd_data_r;
    if (rd_vld_r && mode_r == ilist_pkg::MODE_INSERT) begin
      wr_en   = 1'b1;
      wr_addr = proc_idx_r + AW'(1);
    end else if (rd_vld_r && mode_r == ilist_pkg::MODE_REMOVE) begin
      wr_en   = 1'b1;
      wr_addr = proc_idx_r - AW'(1);
    end else if (cmd.finish && err == ilist_pkg::STS_OK) begin
      wr_data = value_r;
      if (mode_r == ilist_pkg::MODE_APPEND) begin
        wr_en   = 1'b1;
        wr_addr = AW'(n_x);
      end else if (mode_r == ilist_pkg::MODE_INSERT) begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos_x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.finish) begin
        cnt_r <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= rd_idx_r;
    if (cmd.load) begin
      mode_r  <= in_mode;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.init) begin
      rd_idx_r <= start_x[AW-1:0];
      acc_r    <= '0;
      hit_r    <= 1'b0;
      best_r   <= '0;
    end else begin
      if (cmd.issue) begin
        rd_idx_r <= down ? rd_idx_r - AW'(1) : rd_idx_r + AW'(1);
      end
      if (rd_vld_r) begin
        case (mode_r)
          ilist_pkg::MODE_COUNT: begin
            if (pmatch) begin
              acc_r <= acc_r + CW'(1);
            end
          end
          ilist_pkg::MODE_FIND: begin
            if (pmatch && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= proc_idx_r;
            end
          end
          ilist_pkg::MODE_MAX: begin
            if (!hit_r || $signed(rd_data_r) > best_r) begin
              hit_r  <= 1'b1;
              best_r <= $signed(rd_data_r);
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (cmd.finish) begin
      status_r <= status_nxt;
      answer_r <= answer_nxt;
      length_r <= ilist_pkg::LEN_W'(len_nxt);
    end
  end

  assign out_status = status_r;
  assign out_answer = answer_r;
  assign out_length = length_r;

endmodule

`default_nettype wire

@@ src/ilist_ctrl.sv @@
`default_nettype none

module ilist_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  output      logic            out_valid,
  input  wire logic            out_ready,
  input  wire ilist_pkg::sts_t sts,
  output      ilist_pkg::cmd_t cmd
);

  ilist_pkg::state_t state_r;
  ilist_pkg::state_t state_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilist_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == ilist_pkg::S_IDLE);
    case (state_r)
      ilist_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ilist_pkg::S_DECODE;
        end
      end
      ilist_pkg::S_DECODE: begin
        cmd.init  = 1'b1;
        state_nxt = sts.walk ? ilist_pkg::S_WALK : ilist_pkg::S_FINISH;
      end
      ilist_pkg::S_WALK: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_nxt = ilist_pkg::S_DRAIN;
        end
      end
      ilist_pkg::S_DRAIN: begin
        state_nxt = ilist_pkg::S_FINISH;
      end
      ilist_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ilist_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ilist_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ src/ilist_chk.sv @@
`default_nettype none

module ilist_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic        [ilist_pkg::STS_W-1:0] out_status,
  input wire logic signed [ilist_pkg::VAL_W-1:0] out_answer,
  input wire logic        [ilist_pkg::LEN_W-1:0] out_length
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_answer)
      && $stable(out_length))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ilist_pkg::STS_FULL || out_status == ilist_pkg::STS_RANGE
      || out_status == ilist_pkg::STS_NOTFOUND || out_status == ilist_pkg::STS_EMPTY)
      |-> out_answer == '0)
    else $error("error result with non-zero answer");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ilist_pkg::STS_EMPTY |-> out_length == '0)
    else $error("empty status with non-zero length");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("result beat without a pending request");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind indexed_integer_list_engine_unit ilist_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_answer (out_ch.answer),
  .out_length (out_ch.length)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_DEPTH     = 256;
  localparam int TOTAL_REQS     = 950;
  localparam int PHASE_REQS     = 317;
  localparam int HOLD_AT        = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [ilist_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [ilist_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic        [ilist_pkg::MODE_W-1:0] mode;
    logic signed [ilist_pkg::VAL_W-1:0]  value;
    logic        [ilist_pkg::POS_W-1:0]  position;
  } list_req_t;

  typedef struct packed {
    logic        [ilist_pkg::STS_W-1:0] status;
    logic signed [ilist_pkg::VAL_W-1:0] answer;
    logic        [ilist_pkg::LEN_W-1:0] length;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  ilist_in_if  in_ch ();
  ilist_out_if out_ch ();

  indexed_integer_list_engine_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  list_req_t          request_q[$];
  list_rsp_t          awaited_results[$];
  list_req_t          offered_req;
  bit                 req_offered;
  logic signed [31:0] list_mem[LIST_DEPTH];
  int                 list_len;
  int                 gen_len;
  int                 accepted_reqs;
  int                 results_seen;
  int                 fault_count;
  int                 quiet_cycles;
  int                 hold_left;
  bit                 hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_fault(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fault_count++;
  endtask

  function automatic int idle_pct(input bit rx);
    if (accepted_reqs < PHASE_REQS) return rx ? 67 : 25;
    if (accepted_reqs < 2 * PHASE_REQS) return rx ? 25 : 67;
    return 0;
  endfunction

  // Mirror one request on the list and give the result it must produce.
  task automatic apply_list_op(input list_req_t r, output list_rsp_t e);
    int n;
    int k;
    int hits;
    logic signed [31:0] best;
    n = list_len;
    e.status = ilist_pkg::STS_OK;
    e.answer = '0;
    case (r.mode)
      ilist_pkg::MODE_APPEND: begin
        if (n >= LIST_DEPTH) e.status = ilist_pkg::STS_FULL;
        else begin
          list_mem[n] = r.value;
          n++;
        end
      end
      ilist_pkg::MODE_INSERT: begin
        if (int'(r.position) > n) e.status = ilist_pkg::STS_RANGE;
        else if (n >= LIST_DEPTH) e.status = ilist_pkg::STS_FULL;
        else begin
          for (k = n; k > int'(r.position); k--) list_mem[k] = list_mem[k-1];
          list_mem[r.position] = r.value;
          n++;
        end
      end
      ilist_pkg::MODE_REMOVE: begin
        if (int'(r.position) >= n) e.status = ilist_pkg::STS_RANGE;
        else begin
          for (k = int'(r.position); k + 1 < n; k++) list_mem[k] = list_mem[k+1];
          n--;
        end
      end
      ilist_pkg::MODE_COUNT: begin
        hits = 0;
        for (k = 0; k < n; k++) if (list_mem[k] == r.value) hits++;
        e.answer = hits;
      end
      ilist_pkg::MODE_FIND: begin
        e.status = ilist_pkg::STS_NOTFOUND;
        for (k = 0; k < n; k++) begin
          if (list_mem[k] == r.value) begin
            e.status = ilist_pkg::STS_OK;
            e.answer = k;
            break;
          end
        end
      end
      ilist_pkg::MODE_MAX: begin
        if (n == 0) e.status = ilist_pkg::STS_EMPTY;
        else begin
          best = list_mem[0];
          for (k = 1; k < n; k++) if (list_mem[k] > best) best = list_mem[k];
          e.answer = best;
        end
      end
      default: ;
    endcase
    list_len = n;
    e.length = n[ilist_pkg::LEN_W-1:0];
  endtask

  task automatic push_req(input logic [ilist_pkg::MODE_W-1:0] mode,
                          input logic signed [31:0] value, input int position);
    list_req_t r;
    r.mode = mode;
    r.value = value;
    r.position = position[ilist_pkg::POS_W-1:0];
    case (mode)
      ilist_pkg::MODE_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
      ilist_pkg::MODE_INSERT: if (position <= gen_len && gen_len < LIST_DEPTH) gen_len++;
      ilist_pkg::MODE_REMOVE: if (position < gen_len) gen_len--;
      default: ;
    endcase
    request_q.push_back(r);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] pool[8];
    pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd42, -32'sd42,
             32'h8000_0000, 32'h7fff_ffff};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic int pick_position(input int limit);
    if (limit >= 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, limit);
    return $urandom_range(0, 511);
  endfunction

  task automatic build_stimulus();
    int r;
    push_req(ilist_pkg::MODE_MAX, 0, 0);
    push_req(ilist_pkg::MODE_COUNT, 0, 0);
    push_req(ilist_pkg::MODE_FIND, 0, 0);
    push_req(ilist_pkg::MODE_REMOVE, 0, 0);
    push_req(ilist_pkg::MODE_INSERT, 1, 1);
    push_req(ilist_pkg::MODE_INSERT, 32'h8000_0000, 0);
    push_req(ilist_pkg::MODE_APPEND, 32'h7fff_ffff, 0);
    push_req(ilist_pkg::MODE_APPEND, 0, 0);
    push_req(ilist_pkg::MODE_APPEND, -1, 0);
    push_req(ilist_pkg::MODE_INSERT, 5, gen_len);
    push_req(ilist_pkg::MODE_INSERT, 5, 0);
    push_req(ilist_pkg::MODE_COUNT, 5, 0);
    push_req(ilist_pkg::MODE_FIND, 5, 0);
    push_req(ilist_pkg::MODE_FIND, 12345, 0);
    push_req(ilist_pkg::MODE_MAX, 0, 0);
    push_req(ilist_pkg::MODE_REMOVE, 0, gen_len);
    push_req(ilist_pkg::MODE_REMOVE, 0, 511);
    push_req(ilist_pkg::MODE_INSERT, 9, 256);
    push_req(ilist_pkg::MODE_INSERT, 9, 511);
    push_req(MODE_SPARE_6, 32'h5555_5555, 170);
    push_req(MODE_SPARE_7, 32'haaaa_aaaa, 341);
    push_req(ilist_pkg::MODE_REMOVE, 0, 0);
    push_req(ilist_pkg::MODE_REMOVE, 0, gen_len - 1);
    push_req(ilist_pkg::MODE_COUNT, -1, 0);

    // fill to capacity, then hit the full cases
    while (gen_len < LIST_DEPTH) begin
      if ($urandom_range(0, 3) == 0)
        push_req(ilist_pkg::MODE_INSERT, pick_value(), $urandom_range(0, gen_len));
      else push_req(ilist_pkg::MODE_APPEND, pick_value(), 0);
    end
    push_req(ilist_pkg::MODE_APPEND, 3, 0);
    push_req(ilist_pkg::MODE_INSERT, 3, 0);
    push_req(ilist_pkg::MODE_INSERT, 3, LIST_DEPTH);
    push_req(ilist_pkg::MODE_INSERT, 3, LIST_DEPTH + 1);
    push_req(ilist_pkg::MODE_REMOVE, 0, LIST_DEPTH);
    push_req(ilist_pkg::MODE_MAX, 0, 0);
    push_req(ilist_pkg::MODE_COUNT, pick_value(), 0);
    push_req(ilist_pkg::MODE_FIND, pick_value(), 0);
    push_req(ilist_pkg::MODE_REMOVE, 0, LIST_DEPTH - 1);
    push_req(ilist_pkg::MODE_INSERT, pick_value(), LIST_DEPTH - 1);
    push_req(ilist_pkg::MODE_APPEND, 3, 0);

    while (request_q.size() < TOTAL_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 22) push_req(ilist_pkg::MODE_APPEND, pick_value(), pick_position(511));
      else if (r < 40)
        push_req(ilist_pkg::MODE_INSERT, pick_value(), pick_position(gen_len));
      else if (r < 72)
        push_req(ilist_pkg::MODE_REMOVE, pick_value(), pick_position(gen_len - 1));
      else if (r < 80) push_req(ilist_pkg::MODE_COUNT, pick_value(), pick_position(511));
      else if (r < 88) push_req(ilist_pkg::MODE_FIND, pick_value(), pick_position(511));
      else if (r < 96) push_req(ilist_pkg::MODE_MAX, pick_value(), pick_position(511));
      else push_req($urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7, pick_value(),
                    pick_position(511));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.value = '0;
    in_ch.position = '0;
    out_ch.ready = 1'b0;
    req_offered = 1'b0;
    list_len = 0;
    gen_len = 0;
    accepted_reqs = 0;
    results_seen = 0;
    fault_count = 0;
    quiet_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;
    build_stimulus();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (request_q.size() != 0 || req_offered || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!req_offered) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        offered_req = request_q.pop_front();
        req_offered = 1'b1;
        in_ch.valid <= 1'b1;
        in_ch.mode <= offered_req.mode;
        in_ch.value <= offered_req.value;
        in_ch.position <= offered_req.position;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
    end
  end

  always @(posedge clk) begin
    list_rsp_t want;
    list_rsp_t got;
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        apply_list_op(offered_req, want);
        awaited_results.push_back(want);
        req_offered = 1'b0;
        accepted_reqs++;
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.status = out_ch.status;
        got.answer = out_ch.answer;
        got.length = out_ch.length;
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_fault($sformatf("result beat with nothing awaited: status %0d answer %0d len %0d",
                                 got.status, got.answer, got.length));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_fault($sformatf("beat %0d status %0d, want %0d",
                                   results_seen, got.status, want.status));
          if (got.answer !== want.answer)
            report_fault($sformatf("beat %0d answer %0d, want %0d",
                                   results_seen, got.answer, want.answer));
          if (got.length !== want.length)
            report_fault($sformatf("beat %0d length %0d, want %0d",
                                   results_seen, got.length, want.length));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat for %0d cycles", quiet_cycles);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

endmodule
